// File: design/mtis_pkg.sv
// ============================================================================
// mtis_pkg: shared types and constants for the move table interval search
// Holds the table row layout, the action codes, the sequencer states and the
// result bundle of the shared compare/add/subtract unit.
// ============================================================================
`default_nettype none

package mtis_pkg;

    // Default sizing of the move table and of the step counter
    localparam int MTIS_TABLE_ROWS = 4096;
    localparam int MTIS_COUNT_BITS = 16;

    // Widths fixed by the ports
    localparam int PTR_W = 12;
    localparam int SUM_W = 10;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_EXTEND  = 2'd2;

    // One row of the move table as stored in memory
    typedef struct packed {
        logic [7:0]       head;
        logic [7:0]       len;
        logic [PTR_W-1:0] ptr;
        logic [7:0]       offs;
    } row_t;

    // Outputs of the shared compare/add/subtract unit
    typedef struct packed {
        logic             hit;     // row head equals the search symbol
        logic [7:0]       len_m1;  // effective run length minus one
        logic             ge;      // offset at or beyond the run length
        logic [SUM_W-1:0] rem;     // offset minus the run length
        logic [SUM_W-1:0] sum;     // offset plus the row's destination offset
    } alu_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST_RD,
        ST_CLAMP,
        ST_CLAMP_RD,
        ST_LO_ISSUE,
        ST_LO_CHK,
        ST_HI_ISSUE,
        ST_HI_CHK,
        ST_CHECK,
        ST_MAP_ISSUE,
        ST_MAP_PTR,
        ST_MAP_NORM,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// File: design/mtis_ram.sv
// ============================================================================
// mtis_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module mtis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/mtis_alu.sv
// ============================================================================
// mtis_alu: shared compare and arithmetic unit
// Checks a row head against the symbol and works the offset arithmetic of the
// pointer mapping and the run-length normalization.
// ============================================================================
`default_nettype none

module mtis_alu
    import mtis_pkg::*;
(
    input  wire row_t             row,
    input  wire logic [7:0]       sym,
    input  wire logic [SUM_W-1:0] off,
    output alu_res_t              res
);

    logic [7:0]       len_eff;
    logic [SUM_W-1:0] len_w;

    // A stored length of zero counts as one
    assign len_eff = (row.len == 8'd0) ? 8'd1 : row.len;
    assign len_w   = {{(SUM_W-8){1'b0}}, len_eff};

    assign res.hit    = (row.head == sym);
    assign res.len_m1 = len_eff - 8'd1;
    assign res.ge     = (off >= len_w);
    assign res.rem    = off - len_w;
    assign res.sum    = off + {{(SUM_W-8){1'b0}}, row.offs};

endmodule

`default_nettype wire

// File: design/move_table_interval_search_unit.sv
// ============================================================================
// move_table_interval_search_unit: backward search over a run-length move table
// Loads move table rows, restarts a suffix interval and extends it by one
// symbol per transaction, reporting liveness, step count and both bounds.
// ============================================================================
// One input transaction gives exactly one result transaction. The block works
// on one transaction at a time: in_ready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// transaction is taken. A load writes its row, a restart reads the last row,
// and an extend on a dead interval goes straight to the result state. A live
// extend pulls the end back onto a shrunk table when needed, scans rows
// forward for the start and backward for the end, checks the interval, and
// maps both ends through the row pointers, normalizing each mapped offset
// across run boundaries. An extend whose interval empties in the scan stops
// after the check. Any transaction waits in its result state while the
// previous result is still held in the output register. All of this runs
// through the single read port of the table memory, one row per cycle, with a
// shared compare/add/subtract unit judging each row. The table has no reset:
// rows must be loaded before a search touches them. row_count is clamped to
// the range 1..TABLE_ROWS when written and must only be written while idle.
`default_nettype none

module move_table_interval_search_unit
    import mtis_pkg::*;
#(
    parameter int TABLE_ROWS = MTIS_TABLE_ROWS,
    parameter int COUNT_BITS = MTIS_COUNT_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [11:0] row_index,
    input  wire logic [7:0]  row_head,
    input  wire logic [7:0]  row_length,
    input  wire logic [11:0] row_pointer,
    input  wire logic [7:0]  row_offset,
    input  wire logic [7:0]  symbol,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             alive,
    output logic [15:0]      step_count,
    output logic [12:0]      start_run,
    output logic [8:0]       start_offset,
    output logic signed [12:0] end_run,
    output logic [8:0]       end_offset
);

    localparam int ROW_BITS = $clog2(TABLE_ROWS);
    localparam int RUN_W    = ROW_BITS + 2;     // holds 0..TABLE_ROWS and -1
    localparam int CFG_W    = ROW_BITS + 14;
    localparam int IDX_W    = ROW_BITS + 12;
    localparam logic signed [RUN_W-1:0] RUN_ONE = RUN_W'(1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic signed [RUN_W-1:0]   rows_reg;
    logic signed [RUN_W-1:0]   lo_run_reg, lo_run_next;
    logic [8:0]                lo_off_reg, lo_off_next;
    logic signed [RUN_W-1:0]   hi_run_reg, hi_run_next;
    logic [8:0]                hi_off_reg, hi_off_next;
    logic                      dead_reg, dead_next;
    logic [COUNT_BITS-1:0]     steps_reg, steps_next;
    logic [7:0]                sym_reg, sym_next;
    logic                      fix_off_reg, fix_off_next;
    logic                      which_reg, which_next;
    logic signed [RUN_W-1:0]   m_run_reg, m_run_next;
    logic [SUM_W-1:0]          m_off_reg, m_off_next;
    logic signed [RUN_W-1:0]   map_run_reg, map_run_next;
    logic [8:0]                map_off_reg, map_off_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      alive_reg, alive_next;
    logic [15:0]               step_count_reg, step_count_next;
    logic [12:0]               start_run_reg, start_run_next;
    logic [8:0]                start_off_reg, start_off_next;
    logic [12:0]               end_run_reg, end_run_next;
    logic [8:0]                end_off_reg, end_off_next;

    // ------------------------------------------------------------------
    // Table memory and shared unit
    // ------------------------------------------------------------------
    logic                      ram_we;
    logic [ROW_BITS-1:0]       ram_waddr;
    logic signed [RUN_W-1:0]   rd_run;
    logic [$bits(row_t)-1:0]   ram_rdata;
    row_t                      row_wr;
    row_t                      row_rd;
    alu_res_t                  alu;

    assign row_wr.head = row_head;
    assign row_wr.len  = row_length;
    assign row_wr.ptr  = row_pointer;
    assign row_wr.offs = row_offset;
    assign row_rd      = row_t'(ram_rdata);

    mtis_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_wr),
        .raddr (rd_run[ROW_BITS-1:0]),
        .rdata (ram_rdata)
    );

    mtis_alu u_alu (
        .row (row_rd),
        .sym (sym_reg),
        .off (m_off_reg),
        .res (alu)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic not_after(
        input logic signed [RUN_W-1:0] sr,
        input logic [8:0]              so,
        input logic signed [RUN_W-1:0] er,
        input logic [8:0]              eo
    );
        return (sr < er) || ((sr == er) && (so <= eo));
    endfunction

    logic [IDX_W-1:0]          idx_w;
    logic                      idx_ok;
    logic [CFG_W-1:0]          cfg_w;
    logic [CFG_W-1:0]          cfg_clamped;
    logic signed [RUN_W-1:0]   rows_m1;
    logic signed [RUN_W-1:0]   lo_inc;
    logic signed [RUN_W-1:0]   hi_dec;
    logic signed [RUN_W-1:0]   m_inc;
    logic [RUN_W+PTR_W-1:0]    ptr_w;
    logic [RUN_W+PTR_W-1:0]    rows_w;
    logic                      ptr_ok;
    logic [COUNT_BITS-1:0]     steps_inc;
    logic [COUNT_BITS+15:0]    steps_ext;
    logic [RUN_W+12:0]         lo_ext;
    logic [RUN_W+12:0]         hi_ext;

    assign idx_w     = {{ROW_BITS{1'b0}}, row_index};
    assign idx_ok    = (idx_w < IDX_W'(TABLE_ROWS));
    assign ram_waddr = idx_w[ROW_BITS-1:0];

    // Clamp the row count into 1..TABLE_ROWS on the way in
    assign cfg_w       = {{(ROW_BITS+1){1'b0}}, cfg_wr_data};
    assign cfg_clamped = (cfg_w == '0)                ? CFG_W'(1) :
                         (cfg_w > CFG_W'(TABLE_ROWS)) ? CFG_W'(TABLE_ROWS) : cfg_w;

    assign rows_m1 = rows_reg - RUN_ONE;
    assign lo_inc  = lo_run_reg + RUN_ONE;
    assign hi_dec  = hi_run_reg - RUN_ONE;
    assign m_inc   = m_run_reg + RUN_ONE;

    // Destination pointer must land inside the loaded rows
    assign ptr_w  = {{RUN_W{1'b0}}, row_rd.ptr};
    assign rows_w = {{PTR_W{1'b0}}, rows_reg};
    assign ptr_ok = (ptr_w < rows_w);

    assign steps_inc = (&steps_reg) ? steps_reg : steps_reg + COUNT_BITS'(1);

    assign steps_ext = {16'd0, steps_reg};
    assign lo_ext    = {{13{lo_run_reg[RUN_W-1]}}, lo_run_reg};
    assign hi_ext    = {{13{hi_run_reg[RUN_W-1]}}, hi_run_reg};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        lo_run_next  = lo_run_reg;
        lo_off_next  = lo_off_reg;
        hi_run_next  = hi_run_reg;
        hi_off_next  = hi_off_reg;
        dead_next    = dead_reg;
        steps_next   = steps_reg;
        sym_next     = sym_reg;
        fix_off_next = fix_off_reg;
        which_next   = which_reg;
        m_run_next   = m_run_reg;
        m_off_next   = m_off_reg;
        map_run_next = map_run_reg;
        map_off_next = map_off_reg;
        ram_we       = 1'b0;
        rd_run       = m_run_reg;
        in_ready     = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                rd_run = rows_m1;
                if (in_valid)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            ram_we     = idx_ok;
                            state_next = ST_RESP;
                        end
                        ACT_RESTART:
                        begin
                            // Fetch the last row for the end offset
                            state_next = ST_RST_RD;
                        end
                        ACT_EXTEND:
                        begin
                            sym_next   = symbol;
                            state_next = dead_reg ? ST_RESP : ST_CLAMP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_RST_RD:
            begin
                lo_run_next = '0;
                lo_off_next = '0;
                hi_run_next = rows_m1;
                hi_off_next = {1'b0, alu.len_m1};
                dead_next   = 1'b0;
                steps_next  = '0;
                state_next  = ST_RESP;
            end

            ST_CLAMP:
            begin
                fix_off_next = 1'b0;
                rd_run       = rows_m1;
                state_next   = (hi_run_reg >= rows_reg) ? ST_CLAMP_RD : ST_LO_ISSUE;
            end

            ST_CLAMP_RD:
            begin
                // End sat beyond a shrunk table: pull it to the last row
                hi_run_next = rows_m1;
                hi_off_next = {1'b0, alu.len_m1};
                state_next  = ST_LO_ISSUE;
            end

            ST_LO_ISSUE:
            begin
                rd_run     = lo_run_reg;
                state_next = (lo_run_reg >= rows_reg) ? ST_HI_ISSUE : ST_LO_CHK;
            end

            ST_LO_CHK:
            begin
                // Stream rows forward until the head matches
                rd_run = lo_inc;
                if (alu.hit)
                begin
                    state_next = ST_HI_ISSUE;
                end
                else
                begin
                    lo_run_next = lo_inc;
                    lo_off_next = '0;
                    if (lo_inc >= rows_reg)
                    begin
                        state_next = ST_HI_ISSUE;
                    end
                end
            end

            ST_HI_ISSUE:
            begin
                rd_run     = hi_run_reg;
                state_next = hi_run_reg[RUN_W-1] ? ST_CHECK : ST_HI_CHK;
            end

            ST_HI_CHK:
            begin
                // Stream rows backward; offset of a new end row fixed on a hit
                rd_run = hi_dec;
                if (alu.hit)
                begin
                    if (fix_off_reg)
                    begin
                        hi_off_next = {1'b0, alu.len_m1};
                    end
                    state_next = ST_CHECK;
                end
                else
                begin
                    hi_run_next  = hi_dec;
                    hi_off_next  = '0;
                    fix_off_next = 1'b1;
                    if (hi_dec[RUN_W-1])
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (hi_run_reg[RUN_W-1] ||
                    !not_after(lo_run_reg, lo_off_reg, hi_run_reg, hi_off_reg))
                begin
                    dead_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    which_next = 1'b0;
                    m_run_next = lo_run_reg;
                    m_off_next = {1'b0, lo_off_reg};
                    state_next = ST_MAP_ISSUE;
                end
            end

            ST_MAP_ISSUE:
            begin
                rd_run     = m_run_reg;
                state_next = ST_MAP_PTR;
            end

            ST_MAP_PTR:
            begin
                // Follow the pointer; add the destination offset
                rd_run = signed'(ptr_w[RUN_W-1:0]);
                if (!ptr_ok)
                begin
                    dead_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    m_run_next = signed'(ptr_w[RUN_W-1:0]);
                    m_off_next = alu.sum;
                    state_next = ST_MAP_NORM;
                end
            end

            ST_MAP_NORM:
            begin
                rd_run = m_inc;
                if (alu.ge)
                begin
                    // Offset spills into the next run
                    m_off_next = alu.rem;
                    m_run_next = m_inc;
                    if (m_inc >= rows_reg)
                    begin
                        dead_next  = 1'b1;
                        state_next = ST_RESP;
                    end
                end
                else if (!which_reg)
                begin
                    map_run_next = m_run_reg;
                    map_off_next = m_off_reg[8:0];
                    which_next   = 1'b1;
                    m_run_next   = hi_run_reg;
                    m_off_next   = {1'b0, hi_off_reg};
                    state_next   = ST_MAP_ISSUE;
                end
                else
                begin
                    // Both ends mapped: commit and count the step
                    lo_run_next = map_run_reg;
                    lo_off_next = map_off_reg;
                    hi_run_next = m_run_reg;
                    hi_off_next = m_off_reg[8:0];
                    steps_next  = steps_inc;
                    dead_next   = !not_after(map_run_reg, map_off_reg,
                                             m_run_reg, m_off_reg[8:0]);
                    state_next  = ST_RESP;
                end
            end

            ST_RESP:
            begin
                // Hold here until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        alive_next      = alive_reg;
        step_count_next = step_count_reg;
        start_run_next  = start_run_reg;
        start_off_next  = start_off_reg;
        end_run_next    = end_run_reg;
        end_off_next    = end_off_reg;
        if ((state_reg == ST_RESP) && (!out_valid_reg || out_ready))
        begin
            out_valid_next  = 1'b1;
            alive_next      = !dead_reg;
            step_count_next = steps_ext[15:0];
            start_run_next  = lo_ext[12:0];
            start_off_next  = lo_off_reg;
            end_run_next    = hi_ext[12:0];
            end_off_next    = hi_off_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= RUN_ONE;
            lo_run_reg    <= '0;
            lo_off_reg    <= '0;
            hi_run_reg    <= '0;
            hi_off_reg    <= '0;
            dead_reg      <= 1'b1;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_run_reg    <= lo_run_next;
            lo_off_reg    <= lo_off_next;
            hi_run_reg    <= hi_run_next;
            hi_off_reg    <= hi_off_next;
            dead_reg      <= dead_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                rows_reg <= signed'(cfg_clamped[RUN_W-1:0]);
            end
        end
    end

    // Working and payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        fix_off_reg    <= fix_off_next;
        which_reg      <= which_next;
        m_run_reg      <= m_run_next;
        m_off_reg      <= m_off_next;
        map_run_reg    <= map_run_next;
        map_off_reg    <= map_off_next;
        alive_reg      <= alive_next;
        step_count_reg <= step_count_next;
        start_run_reg  <= start_run_next;
        start_off_reg  <= start_off_next;
        end_run_reg    <= end_run_next;
        end_off_reg    <= end_off_next;
    end

    assign out_valid    = out_valid_reg;
    assign alive        = alive_reg;
    assign step_count   = step_count_reg;
    assign start_run    = start_run_reg;
    assign start_offset = start_off_reg;
    assign end_run      = signed'(end_run_reg);
    assign end_offset   = end_off_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // A result only appears after the sequencer reached its result state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised without passing the result state");

    // Every accepted transaction starts sequencer work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction left the sequencer idle");

    // A live interval at rest never has an end run of -1
    a_alive_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !dead_reg) |-> !hi_run_reg[RUN_W-1])
        else $error("live interval with end run of -1");

    // Effective row count stays in range
    a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_reg > '0) && (rows_reg <= signed'(RUN_W'(TABLE_ROWS))))
        else $error("row count out of range");
`endif

endmodule

`default_nettype wire
